>>> sv/weighted_moving_variance_bgs_unit_macros.svh
// ----------------------------------------------------------------------------
// weighted moving variance bgs assertion macros
// clocked assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_MOVING_VARIANCE_BGS_UNIT_MACROS_SVH
`define WEIGHTED_MOVING_VARIANCE_BGS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define WMV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WMV_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define WMV_ASSERT(lbl, clk, rst, prop, msg)
`define WMV_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

>>> sv/wmvbgs_pkg.sv
// ----------------------------------------------------------------------------
// wmvbgs package
// shared constants, register codes and configuration struct
// ----------------------------------------------------------------------------
package wmvbgs_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int LANES      = 3;
  localparam int SMP_W      = 16;
  localparam int VAR_W      = 46;
  localparam int ROOT_W     = VAR_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int LANE_LAT   = 7 + SQRT_STEPS;
  localparam int MERGE_LAT  = 2;
  localparam int PIPE_DEPTH = LANE_LAT + MERGE_LAT;
  localparam int HIST_W     = 2 * LANES * SMP_W;

  localparam logic [15:0] LUMA [LANES] = '{16'd19595, 16'd38470, 16'd7471};

  typedef enum logic [2:0] {
    REG_WEIGHT_CURRENT,
    REG_WEIGHT_PREVIOUS,
    REG_WEIGHT_OLDEST,
    REG_THRESHOLD_ENABLE,
    REG_VAR_LIMIT,
    REG_COLOR_MODE,
    REG_WIDE_SAMPLES,
    REG_FRAME_PIXELS
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] weight_current;
    logic [15:0] weight_previous;
    logic [15:0] weight_oldest;
    logic        threshold_enable;
    logic [31:0] var_limit;
    logic        color_mode;
    logic        wide_samples;
    logic [16:0] frame_pixels;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    weight_current:    16'd32768,
    weight_previous:   16'd19661,
    weight_oldest:     16'd13107,
    threshold_enable:  1'b1,
    var_limit:         32'd225,
    color_mode:        1'b1,
    wide_samples:      1'b0,
    frame_pixels:      17'd65536
  };

endpackage

>>> sv/wmvbgs_sqrt.sv
// ----------------------------------------------------------------------------
// wmvbgs square root
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module wmvbgs_sqrt
  import wmvbgs_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [VAR_W-1:0]  var_in,
  output logic [VAR_W-1:0]  var_out,
  output logic [ROOT_W-1:0] root
);

  logic [VAR_W-1:0] rem [SQRT_STEPS+1];
  logic [VAR_W-1:0] res [SQRT_STEPS+1];
  logic [VAR_W-1:0] vc  [SQRT_STEPS+1];

  assign rem[0] = var_in;
  assign res[0] = '0;
  assign vc[0]  = var_in;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [VAR_W-1:0] BIT = VAR_W'(1) << (VAR_W - 2 - 2 * k);
    logic [VAR_W-1:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        vc[k+1] <= vc[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign var_out = vc[SQRT_STEPS];
  assign root    = res[SQRT_STEPS][ROOT_W-1:0];

endmodule

>>> sv/wmvbgs_lane.sv
// ----------------------------------------------------------------------------
// wmvbgs lane
// weighted mean, weighted variance and square root of one channel
// ----------------------------------------------------------------------------
module wmvbgs_lane
  import wmvbgs_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic [SMP_W-1:0]  smp [3],
  output logic [VAR_W-1:0]  var_out,
  output logic [ROOT_W-1:0] root
);

  logic [15:0] w [3];
  logic [31:0] prod [3];
  logic [33:0] psum;
  logic [25:0] m8;
  logic [SMP_W-1:0] s1r [3];
  logic [SMP_W-1:0] s2r [3];
  logic [25:0] ad [3];
  logic [51:0] sq [3];
  logic [37:0] plo [3];
  logic [37:0] phi [3];
  logic [43:0] term [3];
  logic [VAR_W-1:0] vsum;

  assign w[0] = cfg.weight_current;
  assign w[1] = cfg.weight_previous;
  assign w[2] = cfg.weight_oldest;

  assign psum = 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= smp[i] * w[i];
        s1r[i]  <= smp[i];
        s2r[i]  <= s1r[i];
        if ({2'b0, s2r[i], 8'b0} >= m8) begin
          ad[i] <= {2'b0, s2r[i], 8'b0} - m8;
        end else begin
          ad[i] <= m8 - {2'b0, s2r[i], 8'b0};
        end
        sq[i]   <= ad[i] * ad[i];
        plo[i]  <= sq[i][29:8] * w[i];
        phi[i]  <= sq[i][51:30] * w[i];
        term[i] <= 44'((({22'b0, phi[i]} << 22) + {22'b0, plo[i]}) >> 16);
      end
      m8   <= psum[33:8];
      vsum <= VAR_W'(term[0]) + VAR_W'(term[1]) + VAR_W'(term[2]);
    end
  end

  wmvbgs_sqrt u_sqrt (
    .clk     (clk),
    .en      (en),
    .var_in  (vsum),
    .var_out (var_out),
    .root    (root)
  );

endmodule

>>> sv/wmvbgs_merge.sv
// ----------------------------------------------------------------------------
// wmvbgs merge
// combines lane results into a deviation or a mask value
// ----------------------------------------------------------------------------
module wmvbgs_merge
  import wmvbgs_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic [VAR_W-1:0]  var_in [LANES],
  input  logic [ROOT_W-1:0] root [LANES],
  output logic [7:0]        value
);

  logic [38:0] pr [LANES];
  logic [38:0] pvl [LANES];
  logic [38:0] pvh [LANES];
  logic [VAR_W-1:0] v0;
  logic [ROOT_W-1:0] r0;
  logic [40:0] ysum;
  logic [40:0] lsum;
  logic [40:0] hsum;
  logic [63:0] ycol;
  logic [39:0] thr8;
  logic [18:0] rmono;
  logic [7:0] value_next;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        pr[i]  <= LUMA[i] * root[i];
        pvl[i] <= LUMA[i] * var_in[i][ROOT_W-1:0];
        pvh[i] <= LUMA[i] * var_in[i][VAR_W-1:ROOT_W];
      end
      v0    <= var_in[0];
      r0    <= root[0];
      value <= value_next;
    end
  end

  always_comb begin
    ysum  = 41'(pr[0]) + 41'(pr[1]) + 41'(pr[2]);
    lsum  = 41'(pvl[0]) + 41'(pvl[1]) + 41'(pvl[2]);
    hsum  = 41'(pvh[0]) + 41'(pvh[1]) + 41'(pvh[2]);
    ycol  = (({23'b0, hsum} << ROOT_W) + {23'b0, lsum}) >> 16;
    thr8  = {cfg.var_limit, 8'b0};
    rmono = r0[ROOT_W-1:4];
    if (!cfg.color_mode) begin
      if (cfg.threshold_enable) begin
        value_next = (v0 > VAR_W'(thr8)) ? 8'd255 : 8'd0;
      end else begin
        value_next = (rmono > 19'd255) ? 8'd255 : rmono[7:0];
      end
    end else if (cfg.threshold_enable) begin
      value_next = (ycol > 64'(thr8)) ? 8'd255 : 8'd0;
    end else begin
      value_next = (ysum[40:20] > 21'd255) ? 8'd255 : ysum[27:20];
    end
  end

endmodule

>>> sv/weighted_moving_variance_bgs_unit.sv
// ----------------------------------------------------------------------------
// weighted moving variance bgs unit
// background subtraction over the current and two previous frames
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_*       in   tdata: sample_ch0, sample_ch1, sample_ch2
// m_*       out  tdata: result_value; tlast: last_of_frame
// apb       in   registers at 4*i, 32-bit data
//
// one pixel per cycle while the output is not stalled; the path from transfer to result
// runs through the lane variance pipeline, the 23-stage square root and the merge
// the frame store is read on the transfer and written in the following cycle
// synchronous reset clears the counters, the registers and the pipeline valid bits, not the frame store
// a stalled output freezes the whole pipeline and holds s_tready low
// ----------------------------------------------------------------------------
`include "weighted_moving_variance_bgs_unit_macros.svh"

module weighted_moving_variance_bgs_unit
  import wmvbgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // sample_ch0, sample_ch1, sample_ch2
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // result_value
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int HW = LANES * SMP_W;

  cfg_t cfg;
  logic en;
  logic accept;
  logic [ADDR_W-1:0] pixel_counter;
  logic [1:0] frames_seen;
  logic [16:0] limit;
  logic in_last;
  logic [HW-1:0] cur;
  logic [HIST_W-1:0] hist_mem [MAX_PIXELS];
  logic [HIST_W-1:0] rdata;
  logic [HIST_W-1:0] fwd_word;
  logic [HIST_W-1:0] eff_word;
  logic [HIST_W-1:0] wdata;
  logic fwd;
  logic wr_pending;
  logic [ADDR_W-1:0] s1_addr;
  logic [HW-1:0] s1_cur;
  logic s1_valid;
  logic s1_last;
  logic [PIPE_DEPTH-1:0] vpipe;
  logic [PIPE_DEPTH-1:0] lpipe;
  logic [SMP_W-1:0] smp [LANES][3];
  logic [VAR_W-1:0] lane_var [LANES];
  logic [ROOT_W-1:0] lane_root [LANES];

  assign pready   = 1'b1;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_WEIGHT_CURRENT:    cfg.weight_current    <= pwdata[15:0];
        REG_WEIGHT_PREVIOUS:   cfg.weight_previous   <= pwdata[15:0];
        REG_WEIGHT_OLDEST:     cfg.weight_oldest     <= pwdata[15:0];
        REG_THRESHOLD_ENABLE:  cfg.threshold_enable  <= pwdata[0];
        REG_VAR_LIMIT:         cfg.var_limit         <= pwdata;
        REG_COLOR_MODE:        cfg.color_mode        <= pwdata[0];
        REG_WIDE_SAMPLES:      cfg.wide_samples      <= pwdata[0];
        REG_FRAME_PIXELS:      cfg.frame_pixels      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_WEIGHT_CURRENT:    prdata = 32'(cfg.weight_current);
      REG_WEIGHT_PREVIOUS:   prdata = 32'(cfg.weight_previous);
      REG_WEIGHT_OLDEST:     prdata = 32'(cfg.weight_oldest);
      REG_THRESHOLD_ENABLE:  prdata = 32'(cfg.threshold_enable);
      REG_VAR_LIMIT:         prdata = cfg.var_limit;
      REG_COLOR_MODE:        prdata = 32'(cfg.color_mode);
      REG_WIDE_SAMPLES:      prdata = 32'(cfg.wide_samples);
      REG_FRAME_PIXELS:      prdata = 32'(cfg.frame_pixels);
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    if (cfg.frame_pixels == '0) begin
      limit = 17'd1;
    end else if (cfg.frame_pixels > 17'(MAX_PIXELS)) begin
      limit = 17'(MAX_PIXELS);
    end else begin
      limit = cfg.frame_pixels;
    end
    in_last = ({1'b0, pixel_counter} + 17'd1) >= limit;
    for (int c = 0; c < LANES; c++) begin
      cur[c*SMP_W +: SMP_W] = cfg.wide_samples ? s_tdata[c*SMP_W +: SMP_W]
                                               : {8'b0, s_tdata[c*SMP_W +: 8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_counter <= '0;
      frames_seen   <= '0;
    end else if (accept) begin
      if (in_last) begin
        pixel_counter <= '0;
        if (frames_seen != 2'd2) begin
          frames_seen <= frames_seen + 2'd1;
        end
      end else begin
        pixel_counter <= pixel_counter + 1'b1;
      end
    end
  end

  // frame store, read on transfer, written the following cycle
  assign eff_word = fwd ? fwd_word : rdata;
  assign wdata    = {eff_word[HW-1:0], s1_cur};

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata    <= hist_mem[pixel_counter];
      fwd_word <= wdata;
      s1_addr  <= pixel_counter;
      s1_cur   <= cur;
      s1_last  <= in_last;
    end
    if (wr_pending) begin
      hist_mem[s1_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pending <= 1'b0;
      fwd        <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      wr_pending <= accept;
      if (accept) begin
        fwd <= wr_pending && (s1_addr == pixel_counter);
      end
      if (en) begin
        s1_valid <= accept && (frames_seen == 2'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[PIPE_DEPTH-2:0], s1_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lpipe <= {lpipe[PIPE_DEPTH-2:0], s1_last};
    end
  end

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      smp[c][0] = s1_cur[c*SMP_W +: SMP_W];
      smp[c][1] = cfg.wide_samples ? eff_word[c*SMP_W +: SMP_W]
                                   : {8'b0, eff_word[c*SMP_W +: 8]};
      smp[c][2] = cfg.wide_samples ? eff_word[HW + c*SMP_W +: SMP_W]
                                   : {8'b0, eff_word[HW + c*SMP_W +: 8]};
    end
  end

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    wmvbgs_lane u_lane (
      .clk     (clk),
      .en      (en),
      .cfg     (cfg),
      .smp     (smp[c]),
      .var_out (lane_var[c]),
      .root    (lane_root[c])
    );
  end

  wmvbgs_merge u_merge (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .var_in (lane_var),
    .root   (lane_root),
    .value  (m_tdata)
  );

  assign m_tvalid = vpipe[PIPE_DEPTH-1];
  assign m_tlast  = lpipe[PIPE_DEPTH-1];

  `WMV_ASSERT(a_last_wraps, clk, rst, (accept && in_last) |=> (pixel_counter == '0), "counter did not wrap")
  `WMV_NEVER(a_frames_sat, clk, rst, frames_seen == 2'd3, "frames_seen overflow")
  `WMV_ASSERT(a_write_once, clk, rst, wr_pending |-> $past(accept), "store write without transfer")
  `WMV_ASSERT(a_emit_warm, clk, rst, m_tvalid |-> (frames_seen == 2'd2), "result before two frames")

endmodule

>>> tb/weighted_moving_variance_bgs_unit_test.sv
// ----------------------------------------------------------------------------
// weighted moving variance bgs unit testbench
// drives pixel streams through the block under several register settings,
// predicts each deviation or mask value from its own copy of the frame store
// and checks every output transfer in order, with random gaps and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module weighted_moving_variance_bgs_unit_test
  import wmvbgs_pkg::*;
();

  localparam int STORE_PX  = 64;
  localparam int SETTLE    = PIPE_DEPTH + 8;
  localparam int LIMIT     = 600000;
  localparam int RAND_PX   = 1650;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } pixel_result_t;

  typedef struct {
    bit          thr_en;
    bit          color;
    bit          wide;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
    int          want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // sample_ch0, sample_ch1, sample_ch2
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // result_value
  logic        m_tlast;   // last_of_frame
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  weighted_moving_variance_bgs_unit u_dut (.*);

  // local copy of configuration and state
  longint unsigned w_cur, w_prev, w_old, thr_sq;
  bit              thr_en, color, wide;
  logic [16:0]     fpix;
  logic [15:0]     hist_prev [STORE_PX][3];
  logic [15:0]     hist_old  [STORE_PX][3];
  int              pixel_idx;
  int              frames_done;

  pixel_result_t   expected_px [$];
  int              errors;
  int              results_seen;
  int              pixels_sent;
  int              cycles;
  bit              burst;
  bit              hold_ready;
  int              stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout, %0d results pending", $time, expected_px.size());
      $display("weighted_moving_variance_bgs_unit verification failed");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 64'd0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned spread_term(longint unsigned s, longint unsigned m8,
                                                  longint unsigned w);
    longint          d;
    longint unsigned q;
    d = longint'(s << 8) - longint'(m8);
    q = longint'(d * d);
    return ((q >> 8) * w) >> 16;
  endfunction

  function automatic longint unsigned channel_variance(longint unsigned s0, longint unsigned s1,
                                                       longint unsigned s2);
    longint unsigned m8;
    m8 = (s0 * w_cur + s1 * w_prev + s2 * w_old) >> 8;
    return spread_term(s0, m8, w_cur) + spread_term(s1, m8, w_prev) + spread_term(s2, m8, w_old);
  endfunction

  // advances the local state by one pixel and returns the output it causes
  task automatic predict_pixel(input logic [15:0] smp [3], output bit emit,
                               output pixel_result_t r);
    longint unsigned msk, lim, y, thr8;
    longint unsigned cur [3];
    longint unsigned vr [3];
    int addr;
    msk = wide ? 64'hFFFF : 64'hFF;
    lim = 64'(fpix);
    if (lim == 0) lim = 64'd1;
    if (lim > MAX_PIXELS) lim = 64'(MAX_PIXELS);
    addr = pixel_idx;
    emit = frames_done >= 2;
    for (int c = 0; c < 3; c++) begin
      cur[c] = 64'(smp[c]) & msk;
      vr[c] = channel_variance(cur[c], 64'(hist_prev[addr][c]) & msk,
                               64'(hist_old[addr][c]) & msk);
    end
    thr8 = thr_sq << 8;
    if (!color) begin
      if (thr_en) y = (vr[0] > thr8) ? 64'd255 : 64'd0;
      else y = int_sqrt(vr[0]) >> 4;
    end else if (thr_en) begin
      y = (LUMA[0] * vr[0] + LUMA[1] * vr[1] + LUMA[2] * vr[2]) >> 16;
      y = (y > thr8) ? 64'd255 : 64'd0;
    end else begin
      y = (LUMA[0] * int_sqrt(vr[0]) + LUMA[1] * int_sqrt(vr[1]) +
           LUMA[2] * int_sqrt(vr[2])) >> 20;
    end
    r.value = (y > 255) ? 8'd255 : y[7:0];
    for (int c = 0; c < 3; c++) begin
      hist_old[addr][c] = hist_prev[addr][c];
      hist_prev[addr][c] = cur[c][15:0];
    end
    r.last = (pixel_idx + 1 >= lim);
    if (r.last) begin
      pixel_idx = 0;
      if (frames_done < 2) frames_done++;
    end else begin
      pixel_idx++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 15);
    if (r < 10) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // want >= 0 replaces the predicted value
  task automatic send_pixel(input logic [15:0] c0, c1, c2, input int want);
    logic [15:0]   smp [3];
    bit            emit;
    pixel_result_t r;
    int            n;
    n = pick_gap();
    if (n > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {c2, c1, c0};
    do @(posedge clk); while (!s_tready);
    smp = '{c0, c1, c2};
    predict_pixel(smp, emit, r);
    if (emit) begin
      if (want >= 0) r.value = want[7:0];
      expected_px.push_back(r);
    end
    pixels_sent++;
  endtask

  task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [31:0] wd,
                            output logic [31:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 5'(4 * int'(idx));
    pwdata  <= wd;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] v);
    logic [31:0] rd;
    apb_access(idx, 1'b1, v, rd);
    case (idx)
      REG_WEIGHT_CURRENT:    w_cur  = 64'(v[15:0]);
      REG_WEIGHT_PREVIOUS:   w_prev = 64'(v[15:0]);
      REG_WEIGHT_OLDEST:     w_old  = 64'(v[15:0]);
      REG_THRESHOLD_ENABLE:  thr_en = v[0];
      REG_VAR_LIMIT:         thr_sq = 64'(v);
      REG_COLOR_MODE:        color  = v[0];
      REG_WIDE_SAMPLES:      wide   = v[0];
      REG_FRAME_PIXELS:      fpix   = v[16:0];
      default: ;
    endcase
  endtask

  // input idle, every result in, pipeline empty
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    hold_ready = 1'b1;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [15:0] pick_sample(logic [15:0] near);
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 255));
      default: return near + 16'($urandom_range(0, 40)) - 16'd20;
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst || hold_ready || burst) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 15))
        0, 1, 2: begin
          m_tready <= 1'b0;
          stall_left <= $urandom_range(0, 2);
        end
        3: begin
          m_tready <= 1'b0;
          stall_left <= $urandom_range(5, 25);
        end
        default: m_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_px.size() == 0) begin
        $display("%0t unexpected transfer: value %0d last %0b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        pixel_result_t e;
        e = expected_px.pop_front();
        if (m_tdata !== e.value) begin
          $display("%0t result_value expected %0d actual %0d", $time, e.value, m_tdata);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $display("%0t last_of_frame expected %0b actual %0b", $time, e.last, m_tlast);
          errors++;
        end
        results_seen++;
      end
    end
  end

  dir_row_t dir_rows [20] = '{
    '{0, 0, 1, 16'h0000, 16'h0000, 16'h0000, -1},
    '{0, 0, 1, 16'h0000, 16'h0000, 16'h0000, -1},
    '{0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 0},
    '{0, 0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, -1},
    '{0, 0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, -1},
    '{0, 0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0},
    '{0, 0, 1, 16'h0000, 16'h1234, 16'hFFFF, -1},
    '{0, 0, 1, 16'hFFFF, 16'h0000, 16'h0000, -1},
    '{1, 1, 1, 16'h1234, 16'h5678, 16'h9ABC, -1},
    '{1, 1, 1, 16'h1234, 16'h5678, 16'h9ABC, -1},
    '{1, 1, 1, 16'h1234, 16'h5678, 16'h9ABC, 0},
    '{1, 1, 1, 16'hFFFF, 16'h0000, 16'hFFFF, -1},
    '{1, 1, 1, 16'h0000, 16'hFFFF, 16'h0000, -1},
    '{0, 1, 0, 16'hAB55, 16'hCD55, 16'hEF55, -1},
    '{0, 1, 0, 16'h0055, 16'h1155, 16'h2255, -1},
    '{0, 1, 0, 16'h3355, 16'h4455, 16'h5555, 0},
    '{0, 1, 0, 16'hFF00, 16'h00FF, 16'hA5A5, -1},
    '{1, 0, 0, 16'h00FF, 16'h0000, 16'h0000, -1},
    '{1, 0, 0, 16'h0000, 16'hFFFF, 16'hFFFF, -1},
    '{1, 0, 0, 16'h00FF, 16'h0000, 16'h0000, -1}
  };

  initial begin
    logic [31:0] rd;
    logic [31:0] rst_val [8];
    int rand_px, phases, n;

    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; results_seen = 0; pixels_sent = 0; cycles = 0;
    burst = 1'b0; hold_ready = 1'b1; stall_left = 0;
    pixel_idx = 0; frames_done = 0;
    w_cur = 64'(CFG_RESET.weight_current); w_prev = 64'(CFG_RESET.weight_previous);
    w_old = 64'(CFG_RESET.weight_oldest); thr_en = CFG_RESET.threshold_enable;
    thr_sq = 64'(CFG_RESET.var_limit); color = CFG_RESET.color_mode;
    wide = CFG_RESET.wide_samples; fpix = CFG_RESET.frame_pixels;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // register values after reset
    rst_val = '{32'd32768, 32'd19661, 32'd13107, 32'd1, 32'd225, 32'd1, 32'd0, 32'd65536};
    for (int i = 0; i < 8; i++) begin
      apb_access(reg_idx_t'(i), 1'b0, '0, rd);
      if (rd !== rst_val[i]) begin
        $display("%0t register %0d expected %0h actual %0h", $time, i, rst_val[i], rd);
        errors++;
      end
    end

    // fill every store entry used later, then one frame with results
    cfg_write(REG_FRAME_PIXELS, 32'(STORE_PX));
    cfg_write(REG_WIDE_SAMPLES, 32'd1);
    hold_ready = 1'b0;
    repeat (3 * STORE_PX)
      send_pixel(16'($urandom()), 16'($urandom()), 16'($urandom()), -1);
    drain();

    // directed rows, single pixel frames
    cfg_write(REG_FRAME_PIXELS, 32'd0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].thr_en != thr_en || dir_rows[i].color != color ||
          dir_rows[i].wide != wide) begin
        drain();
        cfg_write(REG_THRESHOLD_ENABLE, 32'(dir_rows[i].thr_en));
        cfg_write(REG_COLOR_MODE, 32'(dir_rows[i].color));
        cfg_write(REG_WIDE_SAMPLES, 32'(dir_rows[i].wide));
        hold_ready = 1'b0;
      end
      send_pixel(dir_rows[i].c0, dir_rows[i].c1, dir_rows[i].c2, dir_rows[i].want);
    end
    drain();

    // random phases
    rand_px = 0;
    phases = 0;
    while (rand_px < RAND_PX) begin
      logic [15:0] b0, b1, b2;
      logic [31:0] fsz;
      bit big;
      cfg_write(REG_WEIGHT_CURRENT, pick_weight());
      cfg_write(REG_WEIGHT_PREVIOUS, pick_weight());
      cfg_write(REG_WEIGHT_OLDEST, pick_weight());
      cfg_write(REG_THRESHOLD_ENABLE, $urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: cfg_write(REG_VAR_LIMIT, 32'd0);
        1: cfg_write(REG_VAR_LIMIT, 32'hFFFF_FFFF);
        2: cfg_write(REG_VAR_LIMIT, $urandom());
        default: cfg_write(REG_VAR_LIMIT, $urandom_range(0, 3000));
      endcase
      cfg_write(REG_COLOR_MODE, $urandom_range(0, 1));
      cfg_write(REG_WIDE_SAMPLES, $urandom_range(0, 1));
      big = 1'b0;
      case ($urandom_range(0, 11))
        0: fsz = 32'd0;
        1: begin fsz = 32'h1FFFF; big = 1'b1; end
        2: begin fsz = 32'(MAX_PIXELS); big = 1'b1; end
        3: fsz = 32'(STORE_PX);
        default: fsz = $urandom_range(1, 24);
      endcase
      cfg_write(REG_FRAME_PIXELS, fsz);
      burst = ($urandom_range(0, 3) == 0);
      hold_ready = 1'b0;
      // large frames only walk addresses already in the store
      n = big ? STORE_PX - 1 - pixel_idx : $urandom_range(60, 200);
      b0 = 16'($urandom()); b1 = 16'($urandom()); b2 = 16'($urandom());
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          b0 = 16'($urandom()); b1 = 16'($urandom()); b2 = 16'($urandom());
        end
        send_pixel(pick_sample(b0), pick_sample(b1), pick_sample(b2), -1);
        rand_px++;
      end
      drain();
      burst = 1'b0;
      phases++;
    end

    $display("%0d pixels in %0d random phases plus directed rows, %0d results checked",
             pixels_sent, phases, results_seen);
    if (errors == 0) begin
      $display("weighted_moving_variance_bgs_unit verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("weighted_moving_variance_bgs_unit verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/wmvbgs_pkg.sv
sv/wmvbgs_sqrt.sv
sv/wmvbgs_lane.sv
sv/wmvbgs_merge.sv
sv/weighted_moving_variance_bgs_unit.sv
tb/weighted_moving_variance_bgs_unit_test.sv
